@@ rtl/cfn_pkg.sv @@
// ----------------------------------------------------------------------------
// cfn_pkg
// shared types and constants of the cover-fit nearest-neighbor scaler
// ----------------------------------------------------------------------------
package cfn_pkg;

    localparam int REG_W    = 13;
    localparam int CRD_W    = 12;
    localparam int IDX_W    = 24;
    localparam int NUM_REGS = 8;
    localparam int ADDR_W   = 3;

    localparam logic [ADDR_W-1:0] REG_RECT_X = 3'd0;
    localparam logic [ADDR_W-1:0] REG_RECT_Y = 3'd1;
    localparam logic [ADDR_W-1:0] REG_RECT_W = 3'd2;
    localparam logic [ADDR_W-1:0] REG_RECT_H = 3'd3;
    localparam logic [ADDR_W-1:0] REG_IMG_W  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_IMG_H  = 3'd5;
    localparam logic [ADDR_W-1:0] REG_SURF_W = 3'd6;
    localparam logic [ADDR_W-1:0] REG_SURF_H = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_CMP,
        ST_DIV1,
        ST_MULOFF,
        ST_DIV2GO,
        ST_DIV2,
        ST_DIV3
    } setup_state_t;

    typedef struct packed {
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
    } coord_t;

    typedef struct packed {
        logic [IDX_W-1:0] src_index;
        logic [IDX_W-1:0] dst_index;
        logic             write_ok;
    } addr_t;

endpackage

@@ rtl/cfn_div.sv @@
// ----------------------------------------------------------------------------
// cfn_div
// radix-2 restoring divider, one quotient bit per clock
// ----------------------------------------------------------------------------
module cfn_div
    import cfn_pkg::*;
#(
    parameter int DVW = 38,
    parameter int DSW = 13
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           done,
    output logic [DVW-1:0] quotient,
    output logic [DSW-1:0] remainder
);

    localparam int CNT_W = $clog2(DVW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVW-1:0]   dvd_reg;
    logic [DSW-1:0]   dsr_reg;
    logic [DSW-1:0]   rem_reg;

    logic [DSW:0]     trial;
    logic [DSW:0]     diff;
    logic             ge;
    logic [DSW-1:0]   rem_next;
    logic [DVW-1:0]   dvd_next;
    logic             last;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DVW-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[DSW-1:0] : trial[DSW-1:0];
        dvd_next = {dvd_reg[DVW-2:0], ge};
        last     = (cnt_reg == CNT_W'(DVW - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !last;
            done_reg <= last;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/cfn_setup.sv @@
// ----------------------------------------------------------------------------
// cfn_setup
// configuration registers and the sequencer that derives scale, crop offset
// and reciprocal from them through one shared divider
// ----------------------------------------------------------------------------
module cfn_setup
    import cfn_pkg::*;
#(
    parameter int DIM_LIMIT = 4096,
    localparam int DW = $clog2(DIM_LIMIT + 1),
    localparam int NW = CRD_W + DW + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [ADDR_W-1:0]   cfg_addr,
    input  logic [REG_W-1:0]    cfg_data,
    output logic                busy,
    output logic [REG_W-1:0]    pos_x,
    output logic [REG_W-1:0]    pos_y,
    output logic [DW-1:0]       rect_w,
    output logic [DW-1:0]       rect_h,
    output logic [DW-1:0]       image_w,
    output logic [DW-1:0]       image_h,
    output logic [DW-1:0]       surf_w,
    output logic [DW-1:0]       surf_h,
    output logic [DW-1:0]       num,
    output logic [DW-1:0]       den,
    output logic [1:0][DW-1:0]  off_q,
    output logic [1:0][DW-1:0]  off_r,
    output logic [NW:0]         recip
);

    localparam int K   = NW;
    localparam int LW  = (DW > REG_W) ? DW : REG_W;
    localparam int OW  = 3 * DW - 1;
    localparam int DVW = (OW > K + 1) ? OW : K + 1;
    localparam logic [DVW-1:0] RECIP_DVD = {{(DVW - 1){1'b0}}, 1'b1} << K;

    function automatic logic [DW-1:0] sat_dim(input logic [REG_W-1:0] v);
        logic [LW-1:0] ve;
        ve = LW'(v);
        if (v == '0)
            return DW'(1);
        else if (ve > LW'(DIM_LIMIT))
            return DW'(DIM_LIMIT);
        else
            return ve[DW-1:0];
    endfunction

    logic [REG_W-1:0]  cfg_reg [NUM_REGS];
    setup_state_t      state_reg;
    setup_state_t      state_next;

    logic [2*DW-1:0]   prod_a_reg;
    logic [2*DW-1:0]   prod_b_reg;
    logic              wide_reg;
    logic [2*DW-2:0]   off_reg;
    logic [OW-1:0]     offden_reg;
    logic [1:0][DW-1:0] off_q_reg;
    logic [1:0][DW-1:0] off_r_reg;
    logic [K:0]        recip_reg;

    logic              wide_cmp;
    logic [DW-1:0]     rsel;
    logic [2*DW-1:0]   off_diff;
    logic [OW-1:0]     offden_next;

    logic              div_start;
    logic [DVW-1:0]    div_dvd;
    logic [DW-1:0]     div_dsr;
    logic              div_done;
    logic [DVW-1:0]    div_quot;
    logic [DW-1:0]     div_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[REG_RECT_X] <= '0;
            cfg_reg[REG_RECT_Y] <= '0;
            cfg_reg[REG_RECT_W] <= REG_W'(1);
            cfg_reg[REG_RECT_H] <= REG_W'(1);
            cfg_reg[REG_IMG_W]  <= REG_W'(1);
            cfg_reg[REG_IMG_H]  <= REG_W'(1);
            cfg_reg[REG_SURF_W] <= REG_W'(1);
            cfg_reg[REG_SURF_H] <= REG_W'(1);
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_addr] <= cfg_data;
        end
    end

    assign pos_x   = cfg_reg[REG_RECT_X];
    assign pos_y   = cfg_reg[REG_RECT_Y];
    assign rect_w  = sat_dim(cfg_reg[REG_RECT_W]);
    assign rect_h  = sat_dim(cfg_reg[REG_RECT_H]);
    assign image_w = sat_dim(cfg_reg[REG_IMG_W]);
    assign image_h = sat_dim(cfg_reg[REG_IMG_H]);
    assign surf_w  = sat_dim(cfg_reg[REG_SURF_W]);
    assign surf_h  = sat_dim(cfg_reg[REG_SURF_H]);

    // height matched when the image is relatively wider than the rectangle
    assign num = wide_reg ? rect_h : rect_w;
    assign den = wide_reg ? image_h : image_w;

    assign wide_cmp    = (prod_a_reg > prod_b_reg);
    assign rsel        = wide_reg ? rect_w : rect_h;
    assign off_diff    = div_quot[2*DW-1:0] - (2*DW)'(rsel);
    assign offden_next = OW'(off_reg) * OW'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_PROD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dsr    = num;
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_PROD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                div_start  = 1'b1;
                div_dvd    = wide_cmp ? DVW'(prod_a_reg) : DVW'(prod_b_reg);
                div_dsr    = wide_cmp ? image_h : image_w;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_done)
                    state_next = ST_MULOFF;
            end
            ST_MULOFF:
            begin
                state_next = ST_DIV2GO;
            end
            ST_DIV2GO:
            begin
                div_start  = 1'b1;
                div_dvd    = DVW'(offden_reg);
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_dvd    = RECIP_DVD;
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_PROD;
            end
        endcase
        if (cfg_we)
            state_next = ST_PROD;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_PROD:
            begin
                prod_a_reg <= (2*DW)'(image_w) * (2*DW)'(rect_h);
                prod_b_reg <= (2*DW)'(image_h) * (2*DW)'(rect_w);
            end
            ST_CMP:
            begin
                wide_reg <= wide_cmp;
            end
            ST_DIV1:
            begin
                if (div_done)
                    off_reg <= off_diff[2*DW-1:1];
            end
            ST_MULOFF:
            begin
                offden_reg <= offden_next;
            end
            ST_DIV2:
            begin
                // offset of at most half the image size, so the quotient fits
                if (div_done)
                begin
                    off_q_reg[0] <= wide_reg ? div_quot[DW-1:0] : '0;
                    off_r_reg[0] <= wide_reg ? div_rem : '0;
                    off_q_reg[1] <= wide_reg ? '0 : div_quot[DW-1:0];
                    off_r_reg[1] <= wide_reg ? '0 : div_rem;
                end
            end
            ST_DIV3:
            begin
                if (div_done)
                    recip_reg <= div_quot[K:0];
            end
            default:
            begin
            end
        endcase
    end

    cfn_div #(
        .DVW (DVW),
        .DSW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign busy  = (state_reg != ST_IDLE);
    assign off_q = off_q_reg;
    assign off_r = off_r_reg;
    assign recip = recip_reg;

endmodule

@@ rtl/cfn_pipe.sv @@
// ----------------------------------------------------------------------------
// cfn_pipe
// six-stage coordinate pipeline: scale by reciprocal, correct, clamp, and
// form the source and surface indices
// ----------------------------------------------------------------------------
module cfn_pipe
    import cfn_pkg::*;
#(
    parameter int DIM_LIMIT = 4096,
    localparam int DW = $clog2(DIM_LIMIT + 1),
    localparam int NW = CRD_W + DW + 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                coord_valid,
    output logic                coord_stall,
    input  coord_t              coord,
    output logic                addr_valid,
    input  logic                addr_stall,
    output addr_t               addr,
    input  logic [REG_W-1:0]    pos_x,
    input  logic [REG_W-1:0]    pos_y,
    input  logic [DW-1:0]       rect_w,
    input  logic [DW-1:0]       rect_h,
    input  logic [DW-1:0]       image_w,
    input  logic [DW-1:0]       image_h,
    input  logic [DW-1:0]       surf_w,
    input  logic [DW-1:0]       surf_h,
    input  logic [DW-1:0]       num,
    input  logic [DW-1:0]       den,
    input  logic [1:0][DW-1:0]  off_q,
    input  logic [1:0][DW-1:0]  off_r,
    input  logic [NW:0]         recip
);

    localparam int NST = 6;
    localparam int K   = NW;
    localparam int MW  = 2 * NW + 1;
    localparam int EW  = (DW + 1 > REG_W + 1) ? DW + 1 : REG_W + 1;
    localparam int PW  = (2 * DW + 1 > IDX_W) ? 2 * DW + 1 : IDX_W;

    logic [NST:1]            v_reg;
    logic [NST:1]            adv;

    logic [1:0][NW-1:0]      s1_n_reg;
    logic signed [EW-1:0]    s1_px_reg;
    logic signed [EW-1:0]    s1_py_reg;
    logic                    s1_inr_reg;

    logic [1:0][NW-1:0]      s2_n_reg;
    logic [1:0][NW-1:0]      s2_q0_reg;
    logic [DW-1:0]           s2_px_reg;
    logic [DW-1:0]           s2_py_reg;
    logic                    s2_ok_reg;

    logic [1:0][NW-1:0]      s3_n_reg;
    logic [1:0][NW-1:0]      s3_q0_reg;
    logic [1:0][NW-1:0]      s3_p_reg;
    logic [PW-1:0]           s3_dst_reg;
    logic                    s3_ok_reg;

    logic [1:0][NW-1:0]      s4_q_reg;
    logic [PW-1:0]           s4_dst_reg;
    logic                    s4_ok_reg;

    logic [1:0][DW-1:0]      s5_s_reg;
    logic [PW-1:0]           s5_dst_reg;
    logic                    s5_ok_reg;

    addr_t                   addr_reg;

    logic [1:0][NW-1:0]      s1_n_next;
    logic signed [EW-1:0]    s1_px_next;
    logic signed [EW-1:0]    s1_py_next;
    logic [1:0][MW-1:0]      s2_prod;
    logic                    s2_ok_next;
    logic signed [EW-1:0]    sw_s;
    logic signed [EW-1:0]    sh_s;
    logic [1:0][NW-1:0]      s3_p_next;
    logic [PW-1:0]           s3_dst_next;
    logic [1:0][NW-1:0]      s4_r;
    logic [1:0][NW-1:0]      s4_q_next;
    logic [1:0][NW:0]        s5_sum;
    logic [1:0][DW-1:0]      s5_size;
    logic [1:0][DW-1:0]      s5_s_next;
    logic [PW-1:0]           s6_src;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        adv[NST] = !v_reg[NST] || !addr_stall;
        for (int k = NST - 1; k >= 1; k--)
            adv[k] = !v_reg[k] || adv[k + 1];
    end

    assign coord_stall = !adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
                v_reg[1] <= coord_valid;
            for (int k = 2; k <= NST; k++)
            begin
                if (adv[k])
                    v_reg[k] <= v_reg[k - 1];
            end
        end
    end

    // stage 1: coordinate times den plus offset remainder
    always_comb
    begin
        s1_n_next[0] = NW'(coord.col) * NW'(den) + NW'(off_r[0]);
        s1_n_next[1] = NW'(coord.row) * NW'(den) + NW'(off_r[1]);
        s1_px_next   = EW'($signed(pos_x)) + $signed(EW'(coord.col));
        s1_py_next   = EW'($signed(pos_y)) + $signed(EW'(coord.row));
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_n_reg   <= s1_n_next;
            s1_px_reg  <= s1_px_next;
            s1_py_reg  <= s1_py_next;
            s1_inr_reg <= (NW'(coord.col) < NW'(rect_w)) && (NW'(coord.row) < NW'(rect_h));
        end
    end

    // stage 2: reciprocal multiply gives a quotient low by at most one
    always_comb
    begin
        sw_s = $signed(EW'(surf_w));
        sh_s = $signed(EW'(surf_h));
        for (int a = 0; a < 2; a++)
            s2_prod[a] = MW'(s1_n_reg[a]) * MW'(recip);
        s2_ok_next = s1_inr_reg && !s1_px_reg[EW-1] && (s1_px_reg < sw_s)
                     && !s1_py_reg[EW-1] && (s1_py_reg < sh_s);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_n_reg <= s1_n_reg;
            for (int a = 0; a < 2; a++)
                s2_q0_reg[a] <= s2_prod[a][K +: NW];
            s2_px_reg <= s1_px_reg[DW-1:0];
            s2_py_reg <= s1_py_reg[DW-1:0];
            s2_ok_reg <= s2_ok_next;
        end
    end

    // stage 3: back-multiply for the remainder, surface index
    always_comb
    begin
        for (int a = 0; a < 2; a++)
            s3_p_next[a] = s2_q0_reg[a] * NW'(num);
        s3_dst_next = PW'(s2_py_reg) * PW'(surf_w) + PW'(s2_px_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_n_reg   <= s2_n_reg;
            s3_q0_reg  <= s2_q0_reg;
            s3_p_reg   <= s3_p_next;
            s3_dst_reg <= s3_dst_next;
            s3_ok_reg  <= s2_ok_reg;
        end
    end

    // stage 4: one correction step
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            s4_r[a]      = s3_n_reg[a] - s3_p_reg[a];
            s4_q_next[a] = s3_q0_reg[a] + NW'(s4_r[a] >= NW'(num));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_q_reg   <= s4_q_next;
            s4_dst_reg <= s3_dst_reg;
            s4_ok_reg  <= s3_ok_reg;
        end
    end

    // stage 5: add the crop quotient and clamp to the image
    always_comb
    begin
        s5_size[0] = image_w;
        s5_size[1] = image_h;
        for (int a = 0; a < 2; a++)
        begin
            s5_sum[a] = (NW + 1)'(off_q[a]) + (NW + 1)'(s4_q_reg[a]);
            if (s5_sum[a] >= (NW + 1)'(s5_size[a]))
                s5_s_next[a] = s5_size[a] - DW'(1);
            else
                s5_s_next[a] = s5_sum[a][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_s_reg   <= s5_s_next;
            s5_dst_reg <= s4_dst_reg;
            s5_ok_reg  <= s4_ok_reg;
        end
    end

    // stage 6: source index, output register
    assign s6_src = PW'(s5_s_reg[1]) * PW'(image_w) + PW'(s5_s_reg[0]);

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            addr_reg.src_index <= s6_src[IDX_W-1:0];
            addr_reg.dst_index <= s5_ok_reg ? s5_dst_reg[IDX_W-1:0] : '0;
            addr_reg.write_ok  <= s5_ok_reg;
        end
    end

    assign addr_valid = v_reg[NST];
    assign addr       = addr_reg;

endmodule

@@ rtl/cover_fit_nearest_scaler_core.sv @@
// ----------------------------------------------------------------------------
// cover_fit_nearest_scaler_core
// nearest-neighbor cover-fit address generator for a destination rectangle
// ----------------------------------------------------------------------------
// Takes one rectangle coordinate per clock while coord_stall is low and returns
// the source pixel index, the surface pixel index and a write flag from the
// output register of the six-stage pipeline; the pipeline moves on whenever its
// next stage is free, so a stalled result does not block new coordinates until
// every stage is full. The scale axis, crop offset and divisor reciprocal come
// from the configuration by three serial divisions in one shared bit-per-clock
// divider: after reset and after every register write coord_stall stays high
// until all three divisions are done.
module cover_fit_nearest_scaler_core
    import cfn_pkg::*;
#(
    parameter int DIM_LIMIT = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              coord_valid,
    output logic              coord_stall,
    input  coord_t            coord,
    output logic              addr_valid,
    input  logic              addr_stall,
    output addr_t             addr,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]  cfg_data
);

    localparam int DW = $clog2(DIM_LIMIT + 1);
    localparam int NW = CRD_W + DW + 1;

    logic                busy;
    logic                pipe_stall;
    logic                pipe_valid;
    logic [REG_W-1:0]    pos_x;
    logic [REG_W-1:0]    pos_y;
    logic [DW-1:0]       rect_w;
    logic [DW-1:0]       rect_h;
    logic [DW-1:0]       image_w;
    logic [DW-1:0]       image_h;
    logic [DW-1:0]       surf_w;
    logic [DW-1:0]       surf_h;
    logic [DW-1:0]       num;
    logic [DW-1:0]       den;
    logic [1:0][DW-1:0]  off_q;
    logic [1:0][DW-1:0]  off_r;
    logic [NW:0]         recip;

    assign pipe_valid  = coord_valid && !busy && !cfg_we;
    assign coord_stall = pipe_stall || busy || cfg_we;

    cfn_setup #(
        .DIM_LIMIT (DIM_LIMIT)
    ) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .busy     (busy),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .rect_w   (rect_w),
        .rect_h   (rect_h),
        .image_w  (image_w),
        .image_h  (image_h),
        .surf_w   (surf_w),
        .surf_h   (surf_h),
        .num      (num),
        .den      (den),
        .off_q    (off_q),
        .off_r    (off_r),
        .recip    (recip)
    );

    cfn_pipe #(
        .DIM_LIMIT (DIM_LIMIT)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .coord_valid (pipe_valid),
        .coord_stall (pipe_stall),
        .coord       (coord),
        .addr_valid  (addr_valid),
        .addr_stall  (addr_stall),
        .addr        (addr),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .image_w     (image_w),
        .image_h     (image_h),
        .surf_w      (surf_w),
        .surf_h      (surf_h),
        .num         (num),
        .den         (den),
        .off_q       (off_q),
        .off_r       (off_r),
        .recip       (recip)
    );

endmodule

@@ rtl/cfn_check.sv @@
// ----------------------------------------------------------------------------
// cfn_check
// port-level checks of the scaler core, bound to the top level
// ----------------------------------------------------------------------------
module cfn_check
    import cfn_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  coord_stall,
    input logic  addr_valid,
    input logic  addr_stall,
    input addr_t addr,
    input logic  cfg_we
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        addr_valid && addr_stall |=> addr_valid && $stable(addr))
        else $error("stalled result changed");

    a_dst_zero: assert property (@(posedge clk) disable iff (!rst_n)
        addr_valid && !addr.write_ok |-> addr.dst_index == '0)
        else $error("dst_index nonzero on clipped pixel");

    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> coord_stall)
        else $error("item taken during register write");

    a_cfg_setup: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> coord_stall)
        else $error("item taken before setup finished");

endmodule

bind cover_fit_nearest_scaler_core cfn_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .coord_stall (coord_stall),
    .addr_valid  (addr_valid),
    .addr_stall  (addr_stall),
    .addr        (addr),
    .cfg_we      (cfg_we)
);

@@ bench/cover_fit_nearest_scaler_core_test.sv @@
// ----------------------------------------------------------------------------
// cover_fit_nearest_scaler_core_test
// self-checking bench for the cover-fit nearest-neighbor address generator
// ----------------------------------------------------------------------------
// Feeds rectangle coordinates under a series of geometry settings, first a
// few hand-picked ones, then random ones, and predicts every source index,
// surface index and write flag in a small scoreboard. Both handshakes idle in
// random bursts; one phase holds the result side off long enough to back the
// pipeline up into its input, another drains all results in mid-phase.
// ----------------------------------------------------------------------------
module cover_fit_nearest_scaler_core_test
    import cfn_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIM_LIMIT   = 4096;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 150;
    localparam int MAX_REPORTS = 40;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 61;

    class addr_tracker;
        logic [REG_W-1:0] regs [NUM_REGS];
        addr_t            pending_addrs [$];
        int               errors;

        function new();
            regs[REG_RECT_X] = '0;
            regs[REG_RECT_Y] = '0;
            regs[REG_RECT_W] = 13'd1;
            regs[REG_RECT_H] = 13'd1;
            regs[REG_IMG_W]  = 13'd1;
            regs[REG_IMG_H]  = 13'd1;
            regs[REG_SURF_W] = 13'd1;
            regs[REG_SURF_H] = 13'd1;
            errors = 0;
        endfunction

        static function longint clamp_dim(logic [REG_W-1:0] v);
            longint d;
            d = longint'(v);
            if (d < 1) d = 1;
            if (d > DIM_LIMIT) d = DIM_LIMIT;
            return d;
        endfunction

        static function longint fit_axis(longint pos, longint off, longint den,
                                         longint num, longint size);
            longint s;
            s = (pos + off) * den / num;
            if (s < 0) s = 0;
            if (s >= size) s = size - 1;
            return s;
        endfunction

        function addr_t scale_addr(coord_t c);
            longint rx, ry, rw, rh, iw, ih, sw, sh;
            longint cx, cy, num, den, xoff, yoff, sx, sy, px, py, lin;
            bit     ok;
            addr_t  a;
            rx = longint'($signed(regs[REG_RECT_X]));
            ry = longint'($signed(regs[REG_RECT_Y]));
            rw = clamp_dim(regs[REG_RECT_W]);
            rh = clamp_dim(regs[REG_RECT_H]);
            iw = clamp_dim(regs[REG_IMG_W]);
            ih = clamp_dim(regs[REG_IMG_H]);
            sw = clamp_dim(regs[REG_SURF_W]);
            sh = clamp_dim(regs[REG_SURF_H]);
            cx = longint'(c.col);
            cy = longint'(c.row);
            // wider image matches height and crops x, otherwise width and crops y
            if (iw * rh > ih * rw)
            begin
                num  = rh;
                den  = ih;
                xoff = (iw * rh / ih - rw) / 2;
                yoff = 0;
            end
            else
            begin
                num  = rw;
                den  = iw;
                xoff = 0;
                yoff = (ih * rw / iw - rh) / 2;
            end
            sx = fit_axis(cx, xoff, den, num, iw);
            sy = fit_axis(cy, yoff, den, num, ih);
            px = rx + cx;
            py = ry + cy;
            ok = cx < rw && cy < rh && px >= 0 && px < sw && py >= 0 && py < sh;
            lin = sy * iw + sx;
            a.src_index = lin[IDX_W-1:0];
            lin = py * sw + px;
            a.dst_index = ok ? lin[IDX_W-1:0] : '0;
            a.write_ok  = ok;
            return a;
        endfunction

        function void note_coord(coord_t c);
            pending_addrs.push_back(scale_addr(c));
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
        endfunction

        function void check_addr(addr_t got);
            addr_t want;
            if (pending_addrs.size() == 0)
            begin
                flag($sformatf("addr item with none pending: expected nothing, actual %h",
                               got));
                return;
            end
            want = pending_addrs.pop_front();
            if (got.src_index !== want.src_index)
                flag($sformatf("src_index expected %0d actual %0d",
                               want.src_index, got.src_index));
            if (got.dst_index !== want.dst_index)
                flag($sformatf("dst_index expected %0d actual %0d",
                               want.dst_index, got.dst_index));
            if (got.write_ok !== want.write_ok)
                flag($sformatf("write_ok expected %0b actual %0b",
                               want.write_ok, got.write_ok));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              coord_valid;
    logic              coord_stall;
    coord_t            coord;
    logic              addr_valid;
    logic              addr_stall;
    addr_t             addr;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_addr;
    logic [REG_W-1:0]  cfg_data;

    addr_tracker       book;
    logic [REG_W-1:0]  setup [NUM_REGS];
    bit                src_jitter    = 1'b0;
    bit                sink_jitter   = 1'b0;
    bit                long_hold_req = 1'b0;
    int                sink_left     = 0;
    int                cycle_count   = 0;

    cover_fit_nearest_scaler_core #(
        .DIM_LIMIT (DIM_LIMIT)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .coord       (coord),
        .addr_valid  (addr_valid),
        .addr_stall  (addr_stall),
        .addr        (addr),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (sink_left > 0)
        begin
            sink_left--;
            addr_stall <= 1'b1;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            sink_left = LONG_HOLD - 1;
            addr_stall <= 1'b1;
        end
        else if (sink_jitter && $urandom_range(0, 5) == 0)
        begin
            sink_left = $urandom_range(0, 11);
            addr_stall <= 1'b1;
        end
        else
            addr_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (coord_valid && !coord_stall) book.note_coord(coord);
            if (addr_valid && !addr_stall) book.check_addr(addr);
            if (cfg_we) book.regs[cfg_addr] = cfg_data;
        end
    end

    task automatic send_coord(input coord_t c);
        if (src_jitter && $urandom_range(0, 5) == 0)
        begin
            coord_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        coord_valid <= 1'b1;
        coord <= c;
        @(posedge clk);
        while (coord_stall) @(posedge clk);
    endtask

    task automatic send_xy(input int x, input int y);
        coord_t c;
        c.col = x[CRD_W-1:0];
        c.row = y[CRD_W-1:0];
        send_coord(c);
    endtask

    task automatic settle(input int tail);
        coord_valid <= 1'b0;
        @(posedge clk);
        while (book.pending_addrs.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic load_setup();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= ADDR_W'(i);
            cfg_data <= setup[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input int rx, input int ry, input int rw, input int rh,
                                input int iw, input int ih, input int sw, input int sh);
        setup[REG_RECT_X] = rx[REG_W-1:0];
        setup[REG_RECT_Y] = ry[REG_W-1:0];
        setup[REG_RECT_W] = rw[REG_W-1:0];
        setup[REG_RECT_H] = rh[REG_W-1:0];
        setup[REG_IMG_W]  = iw[REG_W-1:0];
        setup[REG_IMG_H]  = ih[REG_W-1:0];
        setup[REG_SURF_W] = sw[REG_W-1:0];
        setup[REG_SURF_H] = sh[REG_W-1:0];
        load_setup();
    endtask

    function automatic logic [REG_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       pick_dim = REG_W'($urandom_range(0, 8191));
            1:       pick_dim = REG_W'($urandom_range(1000, 4096));
            default: pick_dim = REG_W'($urandom_range(1, 48));
        endcase
    endfunction

    // edge placed mostly around the surface so that clipping shows up on both sides
    function automatic logic [REG_W-1:0] pick_edge(input logic [REG_W-1:0] surf);
        int off;
        if ($urandom_range(0, 7) == 0)
            off = $urandom_range(0, 8191);
        else
            off = $urandom_range(0, int'(addr_tracker::clamp_dim(surf)) + 16) - 16;
        pick_edge = off[REG_W-1:0];
    endfunction

    function automatic coord_t pick_coord();
        coord_t c;
        if ($urandom_range(0, 7) == 0)
        begin
            c.col = CRD_W'($urandom_range(0, 4095));
            c.row = CRD_W'($urandom_range(0, 4095));
        end
        else
        begin
            c.col = CRD_W'($urandom_range(0,
                        int'(addr_tracker::clamp_dim(setup[REG_RECT_W]))));
            c.row = CRD_W'($urandom_range(0,
                        int'(addr_tracker::clamp_dim(setup[REG_RECT_H]))));
        end
        return c;
    endfunction

    initial
    begin
        book        = new();
        rst_n       = 1'b0;
        coord_valid = 1'b0;
        coord       = '0;
        addr_stall  = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_RECT_X;
        cfg_data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        src_jitter  = 1'b1;
        sink_jitter = 1'b1;

        // geometry left at its reset values
        send_xy(0, 0);
        send_xy(4095, 4095);
        send_xy(1, 0);
        settle(2);

        // wide image, rectangle straddling the surface corner
        set_geometry(-3, 2, 8, 6, 16, 4, 10, 5);
        send_xy(0, 0);
        send_xy(3, 0);
        send_xy(7, 2);
        send_xy(7, 3);
        send_xy(8, 0);
        send_xy(0, 6);
        send_xy(4095, 0);
        send_xy(0, 4095);
        settle(2);

        // largest rectangle and surface, image width saturated
        set_geometry(0, 0, 4096, 4096, 8191, 1, 4096, 4096);
        send_xy(4095, 4095);
        send_xy(0, 0);
        send_xy(2048, 100);
        settle(2);

        // zero and oversized dimensions, most negative edge
        set_geometry(-4096, -1, 0, 8191, 3, 4096, 0, 0);
        send_xy(0, 0);
        send_xy(0, 1);
        send_xy(4095, 4095);
        settle(2);

        // tall image, width matched and y cropped
        set_geometry(4095, 1, 10, 10, 3, 40, 4096, 50);
        send_xy(0, 0);
        send_xy(9, 9);
        send_xy(5, 5);
        settle(2);

        for (int p = 0; p < PHASES; p++)
        begin
            setup[REG_RECT_W] = pick_dim();
            setup[REG_RECT_H] = pick_dim();
            setup[REG_IMG_W]  = pick_dim();
            setup[REG_IMG_H]  = pick_dim();
            setup[REG_SURF_W] = pick_dim();
            setup[REG_SURF_H] = pick_dim();
            setup[REG_RECT_X] = pick_edge(setup[REG_SURF_W]);
            setup[REG_RECT_Y] = pick_edge(setup[REG_SURF_H]);
            load_setup();
            src_jitter  = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_jitter = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (p == 2)
            begin
                src_jitter    = 1'b0;
                long_hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 4 && i == PHASE_ITEMS / 2) settle(0);
                send_coord(pick_coord());
            end
            settle(2);
        end

        settle(20);
        if (book.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
